// ===== rtl/tgp_pkg.sv =====
package tgp_pkg;

  localparam int COARSE_MAX  = 17;
  localparam int VALUE_BITS  = 32;
  localparam int STORE_DEPTH = COARSE_MAX * COARSE_MAX * COARSE_MAX;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int SIZE_BITS   = $clog2(COARSE_MAX + 1);
  localparam int PROD_BITS   = ADDR_BITS + SIZE_BITS;
  localparam int ACC_BITS    = VALUE_BITS + 3;

  localparam int CFG_BITS    = 5;
  localparam int INDEX_BITS  = 13;
  localparam int COORD_BITS  = 6;
  localparam int HALF_BITS   = COORD_BITS - 1;
  localparam int CMP_BITS    = SIZE_BITS + COORD_BITS + 1;

  localparam logic [CFG_BITS-1:0] SIZE_RESET = CFG_BITS'(17);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

// ===== rtl/tgp_ram.sv =====
module tgp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/trilinear_grid_prolongation_top.sv =====
// load request: size square, then size cube with the bounded write in the same step
// query request: 3 multiply steps on one shared multiplier, 8 corner slots through the
//   single-port coarse store, then final add and shift into the result register
// one request in flight at a time; a finished result may wait while the next is taken
// rst_n synchronous active low: clears the sequencer and output valid, size back to 17
// coarse store content is not reset and is undefined until loaded
module trilinear_grid_prolongation_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [tgp_pkg::CFG_BITS-1:0]          cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic [tgp_pkg::INDEX_BITS-1:0]        in_coarse_index,
  input  logic signed [tgp_pkg::VALUE_BITS-1:0] in_coarse_value,
  input  logic [tgp_pkg::COORD_BITS-1:0]        in_fine_x,
  input  logic [tgp_pkg::COORD_BITS-1:0]        in_fine_y,
  input  logic [tgp_pkg::COORD_BITS-1:0]        in_fine_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tgp_pkg::VALUE_BITS-1:0] out_fine_value,
  output logic                                  out_out_of_range
);

  import tgp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_CUBE = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_LAST = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]                   state_r, state_nxt;
  logic [CFG_BITS-1:0]          size_r;
  logic [SIZE_BITS-1:0]         c_eff;
  logic [SIZE_BITS-1:0]         c_r;
  logic                         kind_r;
  logic [INDEX_BITS-1:0]        idx_r;
  logic [VALUE_BITS-1:0]        val_r;
  logic [COORD_BITS-1:0]        crd_x_r, crd_y_r, crd_z_r;
  logic [ADDR_BITS-1:0]         cc_r, t_r, base_r;
  logic [2:0]                   corner_r;
  logic                         rd_pend_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic                         oor_r;
  logic                         out_valid_r;
  logic [VALUE_BITS-1:0]        out_val_r;
  logic                         out_oor_r;

  logic [ADDR_BITS-1:0]         mul_a;
  logic [PROD_BITS-1:0]         prod;
  logic [SIZE_BITS:0]           lim;
  logic                         oor_now;
  logic [1:0]                   odd;
  logic                         corner_ok;
  logic [ADDR_BITS-1:0]         rd_addr;
  logic                         ram_we, ram_re;
  logic [ADDR_BITS-1:0]         ram_addr;
  logic [VALUE_BITS-1:0]        ram_rdata;
  logic signed [ACC_BITS-1:0]   acc_shr;
  logic                         out_free;
  logic                         in_acc;

  always_comb begin
    if (int'(size_r) < 3) begin
      c_eff = SIZE_BITS'(3);
    end else if (int'(size_r) > COARSE_MAX) begin
      c_eff = SIZE_BITS'(COARSE_MAX);
    end else begin
      c_eff = SIZE_BITS'(size_r);
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // shared multiplier, operand a chosen by the step
  always_comb begin
    case (state_r)
      S_SQ:    mul_a = ADDR_BITS'(c_r);
      S_CUBE:  mul_a = cc_r;
      S_MUL1:  mul_a = ADDR_BITS'(crd_z_r[COORD_BITS-1:1]);
      S_MUL2:  mul_a = t_r;
      default: mul_a = '0;
    endcase
  end
  assign prod = PROD_BITS'(mul_a) * PROD_BITS'(c_r);

  // interior is 1 .. 2c-3
  assign lim = {c_r, 1'b0} - (SIZE_BITS+1)'(3);
  assign oor_now = (crd_x_r == '0) || (crd_y_r == '0) || (crd_z_r == '0)
                || (CMP_BITS'(crd_x_r) > CMP_BITS'(lim))
                || (CMP_BITS'(crd_y_r) > CMP_BITS'(lim))
                || (CMP_BITS'(crd_z_r) > CMP_BITS'(lim));

  assign odd = 2'(crd_x_r[0]) + 2'(crd_y_r[0]) + 2'(crd_z_r[0]);

  assign corner_ok = (!corner_r[0] || crd_x_r[0]) && (!corner_r[1] || crd_y_r[0])
                  && (!corner_r[2] || crd_z_r[0]);
  assign rd_addr = base_r + ADDR_BITS'(corner_r[0])
                 + (corner_r[1] ? ADDR_BITS'(c_r) : '0)
                 + (corner_r[2] ? cc_r : '0);

  assign ram_we   = (state_r == S_CUBE) && (PROD_BITS'(idx_r) < prod);
  assign ram_re   = (state_r == S_RD) && corner_ok;
  assign ram_addr = ram_we ? ADDR_BITS'(idx_r) : rd_addr;

  tgp_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (val_r),
    .rdata (ram_rdata)
  );

  assign acc_shr = acc_r >>> odd;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SQ;
      end
      S_SQ: begin
        if (kind_r == KIND_LOAD) begin
          state_nxt = S_CUBE;
        end else if (oor_now) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL1;
        end
      end
      S_CUBE: state_nxt = S_IDLE;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_RD;
      S_RD: begin
        if (corner_r == 3'd7) state_nxt = S_LAST;
      end
      S_LAST: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= SIZE_RESET;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= ram_re;
      if (cfg_wr_en) size_r <= cfg_wr_data;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_kind;
      idx_r   <= in_coarse_index;
      val_r   <= in_coarse_value;
      crd_x_r <= in_fine_x;
      crd_y_r <= in_fine_y;
      crd_z_r <= in_fine_z;
      c_r     <= c_eff;
    end
    case (state_r)
      S_SQ: begin
        cc_r  <= ADDR_BITS'(prod);
        oor_r <= oor_now;
      end
      S_MUL1: t_r <= ADDR_BITS'(prod) + ADDR_BITS'(crd_y_r[COORD_BITS-1:1]);
      S_MUL2: begin
        base_r   <= ADDR_BITS'(prod) + ADDR_BITS'(crd_x_r[COORD_BITS-1:1]);
        corner_r <= 3'd0;
        acc_r    <= '0;
      end
      S_RD: corner_r <= corner_r + 3'd1;
      default: ;
    endcase
    if (rd_pend_r) begin
      acc_r <= acc_r + ACC_BITS'(signed'(ram_rdata));
    end
    if (state_r == S_FIN && out_free) begin
      out_val_r <= oor_r ? '0 : VALUE_BITS'(acc_shr);
      out_oor_r <= oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fine_value   = out_val_r;
  assign out_out_of_range = out_oor_r;

`ifndef SYNTHESIS
  a_write_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CUBE) && (kind_r == KIND_LOAD))
    else $error("store written outside a load request");

  a_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == S_RD) || (state_r == S_LAST))
    else $error("store read data arrived outside the corner sweep");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised without finishing a query");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_val_r == '0))
    else $error("out of range result with nonzero value");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CUBE) |=> !$rose(out_valid_r))
    else $error("load request produced a result");
`endif

endmodule

// ===== sim/trilinear_grid_prolongation_top_tb.sv =====
module trilinear_grid_prolongation_top_tb;
  import tgp_pkg::*;

  localparam int SETTLE_CYCLES  = 20;
  localparam int STUCK_LIMIT    = 4000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int INDEX_TOP      = 4912;
  localparam int COORD_TOP      = 32;

  typedef struct {
    logic                          kind;
    logic [INDEX_BITS-1:0]         index;
    logic signed [VALUE_BITS-1:0]  value;
    logic [COORD_BITS-1:0]         fx;
    logic [COORD_BITS-1:0]         fy;
    logic [COORD_BITS-1:0]         fz;
  } request_t;

  typedef struct {
    logic signed [VALUE_BITS-1:0]  fine_value;
    logic                          out_of_range;
  } fine_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [CFG_BITS-1:0]           cfg_wr_data;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_kind;
  logic [INDEX_BITS-1:0]         in_coarse_index;
  logic signed [VALUE_BITS-1:0]  in_coarse_value;
  logic [COORD_BITS-1:0]         in_fine_x;
  logic [COORD_BITS-1:0]         in_fine_y;
  logic [COORD_BITS-1:0]         in_fine_z;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [VALUE_BITS-1:0]  out_fine_value;
  logic                          out_out_of_range;

  // predictor state
  logic signed [VALUE_BITS-1:0]  coarse_model [STORE_DEPTH];
  bit                            loaded [STORE_DEPTH];
  logic [CFG_BITS-1:0]           size_reg;
  fine_result_t                  pending_fine [$];
  fine_result_t                  next_fine;

  int errors;
  int items_done;
  int burst_left;
  bit gaps_on;
  int holdoff_request = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int stall_seg = 0;
  int cycle_no = 0;
  int stuck;
  logic stall_next;

  trilinear_grid_prolongation_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_coarse_index  (in_coarse_index),
    .in_coarse_value  (in_coarse_value),
    .in_fine_x        (in_fine_x),
    .in_fine_y        (in_fine_y),
    .in_fine_z        (in_fine_z),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fine_value   (out_fine_value),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int grid_points();
    int c;
    c = int'(size_reg);
    if (c < 3) c = 3;
    if (c > COARSE_MAX) c = COARSE_MAX;
    return c;
  endfunction

  function automatic bit in_interior(int c, logic [COORD_BITS-1:0] v);
    return int'(v) >= 1 && int'(v) <= 2 * c - 3;
  endfunction

  // corner n picks +1 on x, y, z by its bits; only odd axes have a second corner
  function automatic int corner_addr(int c, logic [COORD_BITS-1:0] fx,
                                     logic [COORD_BITS-1:0] fy,
                                     logic [COORD_BITS-1:0] fz, int n);
    int ox;
    int oy;
    int oz;
    ox = n & 1;
    oy = (n >> 1) & 1;
    oz = (n >> 2) & 1;
    if ((ox != 0 && !fx[0]) || (oy != 0 && !fy[0]) || (oz != 0 && !fz[0])) return -1;
    return (int'(fx >> 1) + ox) + (int'(fy >> 1) + oy) * c + (int'(fz >> 1) + oz) * c * c;
  endfunction

  function automatic fine_result_t interpolate_fine(logic [COORD_BITS-1:0] fx,
                                                    logic [COORD_BITS-1:0] fy,
                                                    logic [COORD_BITS-1:0] fz);
    fine_result_t r;
    int c;
    int addr;
    int odd;
    int n;
    logic signed [ACC_BITS-1:0] acc;
    c = grid_points();
    r.fine_value = '0;
    r.out_of_range = 1'b1;
    if (!(in_interior(c, fx) && in_interior(c, fy) && in_interior(c, fz))) return r;
    acc = '0;
    for (n = 0; n < 8; n++) begin
      addr = corner_addr(c, fx, fy, fz, n);
      if (addr >= 0) acc = acc + coarse_model[addr];
    end
    odd = int'(fx[0]) + int'(fy[0]) + int'(fz[0]);
    acc = acc >>> odd;
    r.fine_value = acc[VALUE_BITS-1:0];
    r.out_of_range = 1'b0;
    return r;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      if (gaps_on) pause_sender($urandom_range(1, 12));
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  task automatic send_request(request_t rq);
    int c;
    pace();
    @(negedge clk);
    in_valid        <= 1'b1;
    in_kind         <= rq.kind;
    in_coarse_index <= rq.index;
    in_coarse_value <= rq.value;
    in_fine_x       <= rq.fx;
    in_fine_y       <= rq.fy;
    in_fine_z       <= rq.fz;
    do @(posedge clk); while (in_stall);
    c = grid_points();
    if (rq.kind == KIND_LOAD) begin
      // loads past the end of the current grid leave the store alone
      if (int'(rq.index) < c * c * c) begin
        coarse_model[rq.index] = rq.value;
        loaded[rq.index] = 1'b1;
        items_done++;
      end
    end else begin
      pending_fine.push_back(interpolate_fine(rq.fx, rq.fy, rq.fz));
      items_done++;
    end
  endtask

  task automatic send_load(int idx, logic signed [VALUE_BITS-1:0] v);
    request_t rq;
    rq.kind  = KIND_LOAD;
    rq.index = INDEX_BITS'(idx);
    rq.value = v;
    rq.fx    = COORD_BITS'($urandom);
    rq.fy    = COORD_BITS'($urandom);
    rq.fz    = COORD_BITS'($urandom);
    send_request(rq);
  endtask

  task automatic send_query(int x, int y, int z);
    request_t rq;
    rq.kind  = KIND_QUERY;
    rq.index = INDEX_BITS'($urandom_range(0, INDEX_TOP));
    rq.value = $urandom;
    rq.fx    = COORD_BITS'(x);
    rq.fy    = COORD_BITS'(y);
    rq.fz    = COORD_BITS'(z);
    send_request(rq);
  endtask

  // load any corner not yet written, then ask for the point
  task automatic send_valid_query(int x, int y, int z);
    int c;
    int n;
    int addr;
    c = grid_points();
    for (n = 0; n < 8; n++) begin
      addr = corner_addr(c, COORD_BITS'(x), COORD_BITS'(y), COORD_BITS'(z), n);
      if (addr >= 0 && !loaded[addr]) send_load(addr, random_value());
    end
    send_query(x, y, z);
  endtask

  task automatic wait_results_done();
    pause_sender(1);
    while (pending_fine.size() != 0) @(posedge clk);
    // loads finish silently, so give the last one time to land
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid_size(int v);
    wait_results_done();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_BITS'(v);
    @(posedge clk);
    size_reg = CFG_BITS'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_mixed_phase(int n_items);
    int c;
    int cube;
    int target;
    int pick;
    int x;
    int y;
    int z;
    int bad;
    c = grid_points();
    cube = c * c * c;
    target = items_done + n_items;
    gaps_on = $urandom_range(0, 3) != 0;
    while (items_done < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_valid_query($urandom_range(1, 2 * c - 3), $urandom_range(1, 2 * c - 3),
                         $urandom_range(1, 2 * c - 3));
      end else if (pick < 70) begin
        x = $urandom_range(0, COORD_TOP);
        y = $urandom_range(0, COORD_TOP);
        z = $urandom_range(0, COORD_TOP);
        bad = $urandom_range(0, 1) ? 0 : $urandom_range(2 * c - 2, COORD_TOP);
        case ($urandom_range(0, 2))
          0: x = bad;
          1: y = bad;
          default: z = bad;
        endcase
        send_query(x, y, z);
      end else if (pick < 95 || cube > INDEX_TOP) begin
        send_load($urandom_range(0, cube - 1), random_value());
      end else begin
        send_load($urandom_range(cube, INDEX_TOP), random_value());
      end
    end
  endtask

  // reset size 17: extreme sums, floor rounding, every out of range axis
  task automatic test_extreme_values();
    int a;
    int corners [8] = '{0, 1, 17, 18, 289, 290, 306, 307};
    gaps_on = 1'b1;
    for (a = 0; a < 8; a++) send_load(corners[a], 32'sh7FFFFFFF);
    send_query(1, 1, 1);
    send_query(2, 2, 2);
    send_query(1, 1, 2);
    send_load(0, 32'sh80000000);
    send_load(307, 32'sh00000000);
    send_load(306, 32'shFFFFFFFF);
    send_query(1, 2, 2);
    send_query(1, 1, 1);
    send_query(2, 2, 2);
    send_query(0, 1, 1);
    send_query(1, 0, 1);
    send_query(1, 1, 0);
    send_query(32, 32, 32);
    send_query(2, 32, 2);
    send_load(INDEX_TOP, 32'sh5A5A5A5A);
  endtask

  // loads beyond a small grid must not touch entries a larger grid reads
  task automatic test_load_beyond_grid();
    send_load(27, 32'sh12345678);
    set_grid_size(3);
    send_load(26, random_value());
    send_valid_query(3, 3, 3);
    send_valid_query(1, 1, 1);
    send_load(27, 32'sh0F0F0F0F);
    send_load(INDEX_TOP, 32'shF0F0F0F0);
    set_grid_size(17);
    send_valid_query(31, 31, 31);
    send_valid_query(19, 1, 1);
  endtask

  task automatic test_size_sweep();
    int k;
    int sizes [9] = '{3, 0, 17, 31, 5, 2, 11, 18, 8};
    int counts [9] = '{200, 120, 350, 180, 200, 120, 250, 150, 200};
    for (k = 0; k < 9; k++) begin
      set_grid_size(sizes[k]);
      run_mixed_phase(counts[k]);
    end
  endtask

  // receiver holds off while requests keep coming, then everything drains
  task automatic test_output_holdoff();
    set_grid_size(4);
    gaps_on = 1'b0;
    holdoff_request = HOLDOFF_CYCLES;
    repeat (40) send_valid_query($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 5));
    wait_results_done();
  endtask

  always @(negedge clk) begin
    cycle_no++;
    if (holdoff_request > 0) begin
      hold_left = holdoff_request;
      holdoff_request = 0;
    end
    if (stall_seg == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_seg = $urandom_range(20, 200);
    end
    stall_seg--;
    case (stall_mode)
      0: stall_next = 1'b0;
      1: stall_next = 1'($urandom_range(0, 1));
      2: stall_next = (cycle_no % 4) == 0;
      default: stall_next = $urandom_range(0, 9) < 7;
    endcase
    if (hold_left > 0) begin
      stall_next = 1'b1;
      hold_left--;
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_fine.size() == 0) begin
        $error("fine result with no query outstanding");
        errors++;
      end else begin
        next_fine = pending_fine.pop_front();
        if (out_fine_value !== next_fine.fine_value) begin
          $error("fine_value: expected %0d, got %0d", next_fine.fine_value, out_fine_value);
          errors++;
        end
        if (out_out_of_range !== next_fine.out_of_range) begin
          $error("out_of_range: expected %0b, got %0b", next_fine.out_of_range,
                 out_out_of_range);
          errors++;
        end
      end
    end
  end

  initial begin
    stuck = 0;
    @(posedge rst_n);
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_kind         = KIND_LOAD;
    in_coarse_index = '0;
    in_coarse_value = '0;
    in_fine_x       = '0;
    in_fine_y       = '0;
    in_fine_z       = '0;
    out_stall       = 1'b0;
    size_reg        = SIZE_RESET;
    errors          = 0;
    items_done      = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extreme_values();
    test_load_beyond_grid();
    test_size_sweep();
    test_output_holdoff();
    wait_results_done();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
